>>> rtl/fm_phase_discriminator_top_assert.svh
// Assertion macros for the phase discriminator checker.
`ifndef FM_PHASE_DISCRIMINATOR_TOP_ASSERT_SVH
`define FM_PHASE_DISCRIMINATOR_TOP_ASSERT_SVH

// Next-cycle implication, off while reset is high.
`define FMPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmpd: assertion failed");

// Next-cycle implication, checked through reset as well.
`define FMPD_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fmpd: reset assertion failed");

`endif

>>> rtl/fmpd_pkg.sv
package fmpd_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int ANGLE_WIDTH     = 16;

  localparam int MAG_W  = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = SAMPLE_WIDTH + 2;
  localparam int REM_W  = SAMPLE_WIDTH + 2;
  localparam int QUOT_W = ANGLE_FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(QUOT_W);
  localparam int R_W    = ANGLE_FRAC_BITS + 2;
  localparam int M_W    = ANGLE_FRAC_BITS + 3;
  localparam int K_W    = 30;
  localparam int PROD_W = M_W + K_W;

  // pi/4 in Q30
  localparam logic [K_W-1:0] PI4_Q30 = 30'd843314857;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_SYNC   = 1'b1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [ANGLE_WIDTH-1:0]  angle_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [QUOT_W-1:0]              quot_t;

  typedef struct packed {
    logic start;
    mag_t num;
    mag_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    quot_t quot;
  } div_rsp_t;

endpackage

>>> rtl/fmpd_ifs.sv
interface fmpd_in_if;
  import fmpd_pkg::*;
  logic    valid;
  logic    ready;
  logic    func;
  sample_t sample_i;
  sample_t sample_q;
  modport source (output valid, func, sample_i, sample_q, input ready);
  modport sink (input valid, func, sample_i, sample_q, output ready);
endinterface

interface fmpd_out_if;
  import fmpd_pkg::*;
  logic   valid;
  logic   ready;
  angle_t demod_out;
  modport source (output valid, demod_out, input ready);
  modport sink (input valid, demod_out, output ready);
endinterface

interface fmpd_cfg_if;
  logic valid;
  logic ready;
  logic emit_angle;
  modport source (output valid, emit_angle, input ready);
  modport sink (input valid, emit_angle, output ready);
endinterface

>>> rtl/fmpd_div.sv
module fmpd_div (
  input  logic             clk,
  input  logic             rst,
  input  fmpd_pkg::div_req_t req,
  output fmpd_pkg::div_rsp_t rsp
);
  import fmpd_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  mag_t             den;
  quot_t            quot;

  logic [REM_W-1:0] den_ext;
  logic [REM_W-1:0] rem_sub;
  logic [REM_W-1:0] rem_sel;
  logic             fit;

  // restoring radix-2: |num| <= den, so the first step yields the integer bit
  assign den_ext = REM_W'(den);
  assign fit     = rem >= den_ext;
  assign rem_sub = rem - den_ext;
  assign rem_sel = fit ? rem_sub : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= REM_W'(req.num);
      den <= req.den;
      cnt <= CNT_W'(ANGLE_FRAC_BITS);
    end else if (busy) begin
      rem  <= {rem_sel[REM_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], fit};
      cnt  <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> rtl/fm_phase_discriminator_top.sv
// Channel   Dir  Beat payload
// cfg       in   emit_angle (1 = raw angle, 0 = angle difference)
// samples   in   func, sample_i (y), sample_q (x)
// demod     out  demod_out, Q4.12 radians
//
// Sample beat: result passes S_PREP, the 13-step radix-2 divide (ANGLE_FRAC_BITS + 1),
// S_MUL, S_FIN and S_OUT; the next sample is accepted only back in S_IDLE.
// Sync beat: no result. cfg is always ready.
// rst is synchronous; clears state, emit_angle and the stored angle.
// A demod beat not yet taken holds the next result in the last state until taken.
module fm_phase_discriminator_top (
  input logic         clk,
  input logic         rst,
  fmpd_cfg_if.sink    cfg,
  fmpd_in_if.sink     samples,
  fmpd_out_if.source  demod
);
  import fmpd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam logic signed [R_W-1:0]   R_ONE   = R_W'(2**ANGLE_FRAC_BITS);
  localparam logic signed [R_W+1:0]   BASE_1  = (R_W+2)'(2**ANGLE_FRAC_BITS);
  localparam logic signed [R_W+1:0]   BASE_3  = (R_W+2)'(3 * 2**ANGLE_FRAC_BITS);
  localparam logic [PROD_W-1:0]       RND     = PROD_W'(1) << (K_W - 1);
  localparam logic signed [ANGLE_WIDTH:0] SAT_HI = (ANGLE_WIDTH+1)'(2**(ANGLE_WIDTH-1) - 1);
  localparam logic signed [ANGLE_WIDTH:0] SAT_LO = -(ANGLE_WIDTH+1)'(2**(ANGLE_WIDTH-1));

  state_t state;
  logic   emit_angle;
  sample_t y_reg;
  sample_t x_reg;
  logic   num_neg;
  logic   zero;
  logic [M_W-1:0]    m;
  logic [PROD_W-1:0] prod;
  angle_t angle;
  angle_t prev_angle;
  logic   out_valid;
  angle_t out_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [SUM_W-1:0] xs, ys, ays, num_s, den_s, an_s;
  logic signed [R_W-1:0]   q_s, r_s;
  logic signed [R_W+1:0]   m_s;
  logic [M_W-1:0]          m_next;
  logic [PROD_W-1:0]       rnd_sum;
  logic [ANGLE_WIDTH-1:0]  mag_a;
  logic signed [ANGLE_WIDTH:0] diff;
  angle_t diff_sat;
  logic   load_out;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE);
  assign demod.valid   = out_valid;
  assign demod.demod_out = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_angle <= 1'b0;
    end else if (cfg.valid) begin
      emit_angle <= cfg.emit_angle;
    end
  end

  // operand setup for the divide
  always_comb begin
    xs    = SUM_W'(x_reg);
    ys    = SUM_W'(y_reg);
    ays   = y_reg[SAMPLE_WIDTH-1] ? -ys : ys;
    num_s = x_reg[SAMPLE_WIDTH-1] ? xs + ays : xs - ays;
    den_s = x_reg[SAMPLE_WIDTH-1] ? ays - xs : xs + ays;
    an_s  = num_s[SUM_W-1] ? -num_s : num_s;
  end

  assign div_req.start = (state == S_PREP);
  assign div_req.num   = an_s[MAG_W-1:0];
  assign div_req.den   = den_s[MAG_W-1:0];

  fmpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    q_s    = $signed({1'b0, div_rsp.quot});
    r_s    = zero ? -R_ONE : (num_neg ? -q_s : q_s);
    m_s    = (x_reg[SAMPLE_WIDTH-1] ? BASE_3 : BASE_1) - (R_W+2)'(r_s);
    m_next = m_s[R_W+1] ? '0 : m_s[M_W-1:0];
  end

  assign rnd_sum = prod + RND;
  assign mag_a   = ANGLE_WIDTH'(rnd_sum[PROD_W-1:K_W]);

  always_comb begin
    diff = (ANGLE_WIDTH+1)'(angle) - (ANGLE_WIDTH+1)'(prev_angle);
    if (diff > SAT_HI) begin
      diff_sat = SAT_HI[ANGLE_WIDTH-1:0];
    end else if (diff < SAT_LO) begin
      diff_sat = SAT_LO[ANGLE_WIDTH-1:0];
    end else begin
      diff_sat = diff[ANGLE_WIDTH-1:0];
    end
  end

  assign load_out = (state == S_OUT) && (!out_valid || demod.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_angle <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            if (samples.func == FUNC_SYNC) begin
              prev_angle <= '0;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            prev_angle <= angle;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && samples.valid) begin
      y_reg <= samples.sample_i;
      x_reg <= samples.sample_q;
    end
    if (state == S_PREP) begin
      num_neg <= num_s[SUM_W-1];
      zero    <= (den_s == '0);
    end
    if (state == S_DIV && div_rsp.done) begin
      m <= m_next;
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(m) * PROD_W'(PI4_Q30);
    end
    if (state == S_FIN) begin
      angle <= y_reg[SAMPLE_WIDTH-1] ? -mag_a : mag_a;
    end
    if (load_out) begin
      out_data <= emit_angle ? angle : diff_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (demod.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/fmpd_checker.sv
`include "fm_phase_discriminator_top_assert.svh"

module fmpd_assert_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_ready,
  input fmpd_pkg::angle_t demod_out
);
  import fmpd_pkg::*;

  logic in_take;

  assign in_take = in_valid && in_ready;

  `FMPD_ASSERT_NEXT_RST(a_rst_no_beat, rst, !out_valid)

  `FMPD_ASSERT_NEXT(a_busy_after_sample, in_take && in_func == FUNC_SAMPLE, !in_ready)

  `FMPD_ASSERT_NEXT(a_sync_no_beat, in_take && in_func == FUNC_SYNC && !out_valid, !out_valid)

  `FMPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(demod_out))

endmodule

bind fm_phase_discriminator_top fmpd_assert_checker u_fmpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_func   (samples.func),
  .out_valid (demod.valid),
  .out_ready (demod.ready),
  .demod_out (demod.demod_out)
);
